/* sv/fault_code_led_blinker_assert.svh */
// ----------------------------------------------------------------------------
// fault code led blinker assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef FAULT_CODE_LED_BLINKER_ASSERT_SVH
`define FAULT_CODE_LED_BLINKER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FCB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcb assertion failed");

// next-cycle implication
`define FCB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcb assertion failed");

`else

`define FCB_ASSERT_IMP(label, clk, rst, ante, cons)
`define FCB_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/fcb_pkg.sv */
// ----------------------------------------------------------------------------
// fcb_pkg
// shared types and constants of the fault code led blinker
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int ON_W    = 16;
  localparam int OFF_W   = 16;
  localparam int PAUSE_W = 20;
  localparam int TICK_W  = 21;
  localparam int BLINK_W = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int BASE_TICKS  = 1500;
  localparam int PAUSE_SCALE = 5;

  localparam logic [ON_W-1:0]    ON_RESET    = ON_W'(BASE_TICKS);
  localparam logic [OFF_W-1:0]   OFF_RESET   = OFF_W'(BASE_TICKS);
  localparam logic [PAUSE_W-1:0] PAUSE_RESET = PAUSE_W'(BASE_TICKS * PAUSE_SCALE);

  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF_A = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF_B = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 2'd2;

  typedef struct packed {
    logic [ON_W-1:0]    on_ticks;
    logic [OFF_W-1:0]   off_ticks;
    logic [PAUSE_W-1:0] pause_ticks;
  } fcb_cfg_t;

endpackage

/* sv/fcb_if.sv */
// ----------------------------------------------------------------------------
// fcb channel interfaces
// valid/ready channels for tick items and led results
// ----------------------------------------------------------------------------
interface fcb_item_if
  import fcb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [7:0]        fault_number;

  modport source (output valid, output mode, output fault_number, input ready);
  modport sink (input valid, input mode, input fault_number, output ready);
endinterface

interface fcb_result_if;
  logic valid;
  logic ready;
  logic red_led;
  logic power_led;

  modport source (output valid, output red_led, output power_led, input ready);
  modport sink (input valid, input red_led, input power_led, output ready);
endinterface

/* sv/fcb_step.sv */
// ----------------------------------------------------------------------------
// fcb_step
// blink state registers and the per-tick update of counters and red level
// ----------------------------------------------------------------------------
module fcb_step
  import fcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [MODE_W-1:0]  mode,
  input  logic [BLINK_W-1:0] fault_number,
  input  fcb_cfg_t           cfg,
  output logic               red_next
);

  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  tick_count_next;
  logic [BLINK_W-1:0] blink_count;
  logic [BLINK_W-1:0] blink_count_next;
  logic               red_state;
  logic [TICK_W-1:0]  tick_inc;

  always_comb begin
    tick_inc         = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
    tick_count_next  = tick_count;
    blink_count_next = blink_count;
    red_next         = red_state;
    unique case (mode)
      MODE_BLINK: begin
        tick_count_next = tick_inc;
        if (red_state) begin
          if (tick_inc > TICK_W'(cfg.on_ticks)) begin
            tick_count_next = '0;
            if (blink_count != BLINK_MAX) begin
              blink_count_next = blink_count + 1'b1;
            end
            red_next = 1'b0;
          end
        end else if (blink_count < fault_number) begin
          if (tick_inc > TICK_W'(cfg.off_ticks)) begin
            tick_count_next = '0;
            red_next        = 1'b1;
          end
        end else begin
          if (tick_inc > TICK_W'(cfg.pause_ticks)) begin
            tick_count_next  = '0;
            blink_count_next = '0;
          end
        end
      end
      MODE_ON: begin
        red_next = 1'b1;
      end
      MODE_OFF_A, MODE_OFF_B: begin
        red_next = 1'b0;
      end
      default: begin
        red_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      blink_count <= '0;
      red_state   <= 1'b0;
    end else if (advance) begin
      tick_count  <= tick_count_next;
      blink_count <= blink_count_next;
      red_state   <= red_next;
    end
  end

endmodule

/* sv/fault_code_led_blinker.sv */
// ----------------------------------------------------------------------------
// fault_code_led_blinker
// result path: item register (input reg), then result register (result reg)
// throughput: one item per cycle while the result is taken, set by the combinational counter update
// the item register accepts while a finished result waits on the output only if it is empty
// reset: synchronous, clears counters, red level state and valids; config to defaults
// ----------------------------------------------------------------------------
`include "fault_code_led_blinker_assert.svh"

module fault_code_led_blinker
  import fcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fcb_item_if.sink              item,
  fcb_result_if.source          result
);

  fcb_cfg_t           cfg;
  logic               q_valid;
  logic [MODE_W-1:0]  q_mode;
  logic [BLINK_W-1:0] q_fault;
  logic               o_valid;
  logic               o_red;
  logic               advance;
  logic               red_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_ticks    <= ON_RESET;
      cfg.off_ticks   <= OFF_RESET;
      cfg.pause_ticks <= PAUSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ON:    cfg.on_ticks    <= cfg_wdata[ON_W-1:0];
        CFG_OFF:   cfg.off_ticks   <= cfg_wdata[OFF_W-1:0];
        CFG_PAUSE: cfg.pause_ticks <= cfg_wdata[PAUSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = q_valid && (!o_valid || result.ready);
  assign item.ready = !q_valid || advance;

  // item register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.ready) begin
      q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      q_mode  <= item.mode;
      q_fault <= item.fault_number;
    end
  end

  fcb_step u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .mode         (q_mode),
    .fault_number (q_fault),
    .cfg          (cfg),
    .red_next     (red_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_valid || result.ready) begin
      o_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_red <= red_next;
    end
  end

  assign result.valid     = o_valid;
  assign result.red_led   = o_red;
  assign result.power_led = 1'b1;

  `FCB_ASSERT_NXT(a_force_on, clk, rst, advance && (q_mode == MODE_ON), result.red_led)
  `FCB_ASSERT_NXT(a_force_off, clk, rst, advance && ((q_mode == MODE_OFF_A) || (q_mode == MODE_OFF_B)), !result.red_led)
  `FCB_ASSERT_IMP(a_stall_full, clk, rst, !item.ready, q_valid && o_valid && !result.ready)
  `FCB_ASSERT_NXT(a_result_follows, clk, rst, advance, result.valid)

endmodule

/* bench/tb_fault_code_led_blinker.sv */
// ----------------------------------------------------------------------------
// tb_fault_code_led_blinker
// drives tick transactions into the blinker and checks every led result
// against a cycle-free model of the blink code: directed corner cases,
// blink counter saturation, random timing sets under idling and stalls,
// and a long output hold-off that fills the block and stalls its input
// ----------------------------------------------------------------------------
module tb_fault_code_led_blinker;
  timeunit 1ns;
  timeprecision 1ps;

  import fcb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] FORCED_MODES [3] = '{MODE_OFF_A, MODE_ON, MODE_OFF_B};

  typedef struct packed {
    logic red;
    logic green;
  } led_pair_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fcb_item_if   item_ch ();
  fcb_result_if res_ch ();

  fault_code_led_blinker i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch)
  );

  // model state and register copies
  logic [ON_W-1:0]    on_reg;
  logic [OFF_W-1:0]   off_reg;
  logic [PAUSE_W-1:0] pause_reg;
  logic [TICK_W-1:0]  tick_cnt;
  logic [BLINK_W-1:0] blinks_done;
  logic               red_lvl;

  led_pair_t led_queue [$];

  int src_idle_pct;
  int snk_stall_pct;
  int hold_left;
  int errors;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic advance_red_level(logic [MODE_W-1:0] mode, logic [7:0] faults);
    if (mode == MODE_BLINK) begin
      if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
      if (red_lvl) begin
        if (tick_cnt > on_reg) begin
          tick_cnt = '0;
          if (blinks_done != BLINK_MAX) blinks_done = blinks_done + 1'b1;
          red_lvl = 1'b0;
        end
      end else if (blinks_done < faults) begin
        if (tick_cnt > off_reg) begin
          tick_cnt = '0;
          red_lvl = 1'b1;
        end
      end else if (tick_cnt > pause_reg) begin
        tick_cnt = '0;
        blinks_done = '0;
      end
    end else if (mode == MODE_ON) begin
      red_lvl = 1'b1;
    end else begin
      red_lvl = 1'b0;
    end
    return red_lvl;
  endfunction

  task automatic send_tick(logic [MODE_W-1:0] mode, logic [7:0] faults);
    led_pair_t want;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.mode = mode;
    item_ch.fault_number = faults;
    do @(posedge clk); while (!item_ch.ready);
    want.red = advance_red_level(mode, faults);
    want.green = 1'b1;
    led_queue.push_back(want);
  endtask

  task automatic wait_for_leds();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (led_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ON:    on_reg = data[ON_W-1:0];
      CFG_OFF:   off_reg = data[OFF_W-1:0];
      CFG_PAUSE: pause_reg = data[PAUSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [CFG_DATA_W-1:0] on_d, logic [CFG_DATA_W-1:0] off_d,
                            logic [CFG_DATA_W-1:0] pause_d);
    wait_for_leds();
    write_reg(CFG_ON, on_d);
    write_reg(CFG_OFF, off_d);
    write_reg(CFG_PAUSE, pause_d);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    if ($urandom_range(99) < 75) return MODE_BLINK;
    return FORCED_MODES[$urandom_range(2)];
  endfunction

  function automatic logic [7:0] pick_faults();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 8'($urandom_range(4));
    if (r < 8) return 8'($urandom_range(255));
    return 8'($urandom_range(12, 1));
  endfunction

  task automatic test_directed();
    // defaults after reset
    send_tick(MODE_BLINK, 8'd0);
    send_tick(MODE_BLINK, 8'd255);
    send_tick(MODE_ON, 8'd3);
    // zero durations end every phase on the first tick
    set_timing('0, '0, '0);
    repeat (6) send_tick(MODE_BLINK, 8'd2);
    send_tick(MODE_OFF_A, 8'd2);
    send_tick(MODE_ON, 8'd2);
    send_tick(MODE_BLINK, 8'd2);
    send_tick(MODE_OFF_B, 8'd2);
    repeat (2) send_tick(MODE_BLINK, 8'd0);
    repeat (3) send_tick(MODE_BLINK, 8'd255);
    // widest timing values, upper data bits set on the 16 bit registers
    set_timing('1, '1, '1);
    repeat (3) send_tick(MODE_BLINK, 8'd1);
    send_tick(MODE_ON, 8'd1);
    repeat (2) send_tick(MODE_BLINK, 8'd1);
  endtask

  task automatic test_blink_saturation();
    // forced on then one blink tick advances the blink count until it saturates
    set_timing('0, '0, '1);
    repeat (260) begin
      send_tick(MODE_ON, 8'd255);
      send_tick(MODE_BLINK, 8'd255);
    end
    repeat (4) send_tick(MODE_BLINK, 8'd255);
    repeat (2) send_tick(MODE_BLINK, 8'd0);
  endtask

  task automatic test_random_phase(int n, int src_pct, int snk_pct);
    logic [CFG_DATA_W-1:0] pause_d;
    wait_for_leds();
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (2) begin
      if ($urandom_range(3) == 0) pause_d = CFG_DATA_W'($urandom);
      else pause_d = CFG_DATA_W'($urandom_range(12));
      set_timing({4'($urandom), 16'($urandom_range(6))},
                 {4'($urandom), 16'($urandom_range(6))}, pause_d);
      if ($urandom_range(1) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      repeat (n / 2) send_tick(pick_mode(), pick_faults());
    end
  endtask

  task automatic test_output_holdoff();
    wait_for_leds();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_timing(20'd2, 20'd1, 20'd4);
    @(posedge clk);
    hold_left = 300;
    repeat (60) send_tick(pick_mode(), pick_faults());
  endtask

  task automatic test_sender_pause();
    src_idle_pct = 8;
    snk_stall_pct = 8;
    repeat (20) send_tick(pick_mode(), pick_faults());
    wait_for_leds();
    repeat (20) send_tick(pick_mode(), pick_faults());
  endtask

  // result ready, random stalls and counted hold-offs
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_ch.ready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic note_mismatch(string field, logic want, logic got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %b actual %b", field, want, got);
  endtask

  always @(posedge clk) begin
    led_pair_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (led_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: red %b power %b",
                                   res_ch.red_led, res_ch.power_led);
      end else begin
        want = led_queue.pop_front();
        if (res_ch.red_led !== want.red) note_mismatch("red_led", want.red, res_ch.red_led);
        if (res_ch.power_led !== want.green)
          note_mismatch("power_led", want.green, res_ch.power_led);
      end
    end
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_ON;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_BLINK;
    item_ch.fault_number = '0;
    res_ch.ready = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left = 0;
    errors = 0;
    on_reg = ON_RESET;
    off_reg = OFF_RESET;
    pause_reg = PAUSE_RESET;
    tick_cnt = '0;
    blinks_done = '0;
    red_lvl = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_blink_saturation();
    test_random_phase(130, 0, 0);
    test_random_phase(130, 79, 0);
    test_random_phase(130, 0, 79);
    test_random_phase(130, 8, 8);
    test_output_holdoff();
    test_sender_pause();

    wait_for_leds();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/fcb_pkg.sv
sv/fcb_if.sv
sv/fcb_step.sv
sv/fault_code_led_blinker.sv
bench/tb_fault_code_led_blinker.sv
